// ===== rtl/core/text_stream_line_formatter_assert.svh =====
// Assertion macros for the text stream line formatter.
// Used by tslf_back under rtl/core; expects clk and rst_n in scope.
`ifndef TEXT_STREAM_LINE_FORMATTER_ASSERT_SVH
`define TEXT_STREAM_LINE_FORMATTER_ASSERT_SVH

// Checked property, switched off while reset is held
`define TSLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also active during reset
`define TSLF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tslf_pkg.sv =====
// Shared types, constants and character codes for the text stream line formatter.
// No dependencies; imported by every module under rtl/core.
package tslf_pkg;

    // Line counter: BCD digits and the narrowest printed column count
    localparam int NUMBER_DIGITS = 8;
    localparam int NUM_MIN_COLS  = 6;
    localparam int DIG_IDX_W     = $clog2(NUMBER_DIGITS);
    localparam int SIG_W         = $clog2(NUMBER_DIGITS + 1);

    // Longest run: number, tab, then up to four bytes for the character
    localparam int BODY_MAX = 4;
    localparam int RUN_MAX  = NUMBER_DIGITS + 1 + BODY_MAX;
    localparam int RUN_W    = $clog2(RUN_MAX + 1);

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_NONBLANK  = 3'd0,
        REG_NUM_ALL       = 3'd1,
        REG_SHOW_NONPRINT = 3'd2,
        REG_TAB_MARK      = 3'd3,
        REG_END_MARK      = 3'd4,
        REG_SQUEEZE       = 3'd5
    } tslf_reg_idx_t;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
    localparam logic [7:0] CH_HI_CTRL_MIN = 8'h80;
    localparam logic [7:0] CH_HI_CTRL_MAX = 8'h9F;
    localparam logic [7:0] CH_HI_DEL   = 8'hFF;
    localparam logic [7:0] CH_CTRL_OFS = 8'h40;

    typedef struct packed {
        logic nonblank_num;
        logic every_num;
        logic show_nonprint;
        logic tab_mark;
        logic end_mark;
        logic blank_squeeze;
    } tslf_cfg_t;

    typedef logic [NUMBER_DIGITS-1:0][3:0] tslf_bcd_t;

    // One queued request: counter snapshot plus the rendered character bytes
    typedef struct packed {
        tslf_bcd_t                   digits;
        logic [SIG_W-1:0]            sig;
        logic [RUN_W-1:0]            pre_len;
        logic [RUN_W-1:0]            run_len;
        logic [BODY_MAX-1:0][7:0]    body;
    } tslf_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } tslf_qstat_t;

endpackage

// ===== rtl/core/tslf_front.sv =====
// Front part: accepts input bytes, keeps line state, renders character bytes.
// Depends on tslf_pkg; pushes one request per non-dropped byte into tslf_queue.
module tslf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    input  tslf_pkg::tslf_cfg_t   cfg,
    input  tslf_pkg::tslf_qstat_t q_st,
    output logic                  push,
    output tslf_pkg::tslf_entry_t push_entry
);
    import tslf_pkg::*;

    tslf_bcd_t   counter_reg, counter_next;
    logic        at_start_reg, at_start_next;
    logic [1:0]  blank_reg, blank_next;

    logic                 accept, is_nl, sq_hit, drop, num_en, full_cnt;
    logic [1:0]           blank_inc;
    logic [SIG_W-1:0]     sig;
    logic [RUN_W-1:0]     pre_len;
    logic [BODY_MAX-1:0][7:0] body;
    logic [RUN_W-1:0]     body_len;
    tslf_bcd_t            counter_inc;

    // Accept while the queue has room
    assign in_stall = q_st.full;
    assign accept   = in_valid && !q_st.full;
    assign is_nl    = (in_byte == CH_NL);

    // Squeeze: second and later empty lines of a run are dropped
    assign sq_hit    = cfg.blank_squeeze && at_start_reg && is_nl;
    assign blank_inc = (blank_reg < 2'd2) ? blank_reg + 2'd1 : blank_reg;
    assign drop      = sq_hit && (blank_inc > 2'd1);

    // Numbering: nonblank mode overrides number-all
    assign num_en = at_start_reg &&
                    (cfg.nonblank_num ? !is_nl : cfg.every_num);

    // Saturating BCD increment, carry ripples through digits of nine
    always_comb
    begin
        logic carry;
        carry       = 1'b1;
        full_cnt    = 1'b1;
        counter_inc = counter_reg;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (counter_reg[i] != 4'd9)
            begin
                full_cnt = 1'b0;
            end
            if (carry)
            begin
                counter_inc[i] = (counter_reg[i] == 4'd9) ? 4'd0 : counter_reg[i] + 4'd1;
            end
            carry = carry && (counter_reg[i] == 4'd9);
        end
        if (full_cnt)
        begin
            counter_inc = counter_reg;
        end
    end

    // Significant digit count, at least one
    always_comb
    begin
        sig = SIG_W'(1);
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (counter_reg[i] != 4'd0)
            begin
                sig = SIG_W'(i + 1);
            end
        end
    end

    // Prefix length: number columns plus the tab
    always_comb
    begin
        if (!num_en)
        begin
            pre_len = '0;
        end
        else if (RUN_W'(sig) < RUN_W'(NUM_MIN_COLS))
        begin
            pre_len = RUN_W'(NUM_MIN_COLS + 1);
        end
        else
        begin
            pre_len = RUN_W'(sig) + RUN_W'(1);
        end
    end

    // Character rendering: ^I, $, caret and M- notation
    always_comb
    begin
        body     = '0;
        body_len = RUN_W'(1);
        body[0]  = in_byte;
        if (cfg.tab_mark && (in_byte == CH_TAB))
        begin
            body[0]  = CH_CARET;
            body[1]  = CH_I;
            body_len = RUN_W'(2);
        end
        else if (cfg.show_nonprint && !is_nl && (in_byte != CH_TAB))
        begin
            if (in_byte == CH_DEL)
            begin
                body[0]  = CH_CARET;
                body[1]  = CH_QMARK;
                body_len = RUN_W'(2);
            end
            else if (in_byte <= CH_CTRL_MAX)
            begin
                body[0]  = CH_CARET;
                body[1]  = in_byte + CH_CTRL_OFS;
                body_len = RUN_W'(2);
            end
            else if ((in_byte >= CH_HI_CTRL_MIN) && (in_byte <= CH_HI_CTRL_MAX))
            begin
                body[0]  = CH_M;
                body[1]  = CH_DASH;
                body[2]  = CH_CARET;
                body[3]  = in_byte - CH_CTRL_OFS;
                body_len = RUN_W'(4);
            end
            else if (in_byte == CH_HI_DEL)
            begin
                body[0]  = CH_M;
                body[1]  = CH_DASH;
                body[2]  = CH_CARET;
                body[3]  = CH_QMARK;
                body_len = RUN_W'(4);
            end
            else if (in_byte > CH_HI_CTRL_MAX)
            begin
                body[0]  = CH_M;
                body[1]  = CH_DASH;
                body[2]  = {1'b0, in_byte[6:0]};
                body_len = RUN_W'(3);
            end
        end
        else if (cfg.end_mark && is_nl)
        begin
            body[0]  = CH_DOLLAR;
            body[1]  = CH_NL;
            body_len = RUN_W'(2);
        end
    end

    // Request towards the back part
    assign push               = accept && !drop;
    assign push_entry.digits  = counter_reg;
    assign push_entry.sig     = sig;
    assign push_entry.pre_len = pre_len;
    assign push_entry.run_len = pre_len + body_len;
    assign push_entry.body    = body;

    // Line state update
    always_comb
    begin
        counter_next  = counter_reg;
        at_start_next = at_start_reg;
        blank_next    = blank_reg;
        if (accept)
        begin
            if (sq_hit)
            begin
                blank_next = blank_inc;
            end
            if (!drop)
            begin
                if (num_en)
                begin
                    counter_next = counter_inc;
                end
                at_start_next = is_nl;
                if (!is_nl)
                begin
                    blank_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= tslf_bcd_t'(1);
            at_start_reg <= 1'b1;
            blank_reg    <= 2'd0;
        end
        else
        begin
            counter_reg  <= counter_next;
            at_start_reg <= at_start_next;
            blank_reg    <= blank_next;
        end
    end

endmodule

// ===== rtl/core/tslf_queue.sv =====
// Short request queue between the front and back parts.
// Depends on tslf_pkg for the entry type and depth.
module tslf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tslf_pkg::tslf_entry_t push_entry,
    input  logic                  pop,
    output tslf_pkg::tslf_entry_t head,
    output tslf_pkg::tslf_qstat_t q_st
);
    import tslf_pkg::*;

    tslf_entry_t          entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_st.empty = (count_reg == '0);
    assign q_st.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/tslf_back.sv =====
// Back part: walks the head request byte by byte into the output register.
// Depends on tslf_pkg and text_stream_line_formatter_assert.svh; reads tslf_queue.
module tslf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tslf_pkg::tslf_entry_t head,
    input  tslf_pkg::tslf_qstat_t q_st,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last_of_run
);
    import tslf_pkg::*;

`include "text_stream_line_formatter_assert.svh"

    logic [RUN_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 last_reg;

    logic                 advance, fire, is_last;
    logic [RUN_W-1:0]     num_w, k_full, body_pos;
    logic [DIG_IDX_W-1:0] k;
    logic [7:0]           byte_sel;

    // Output register frees up when empty or taken
    assign advance = !out_valid_reg || !out_stall;
    assign fire    = advance && !q_st.empty;
    assign is_last = (idx_reg == head.run_len - RUN_W'(1));
    assign pop     = fire && is_last;

    // Byte at the current run position: number column, tab, or character byte
    assign num_w    = head.pre_len - RUN_W'(1);
    assign k_full   = num_w - RUN_W'(1) - idx_reg;
    assign k        = k_full[DIG_IDX_W-1:0];
    assign body_pos = idx_reg - head.pre_len;

    always_comb
    begin
        if ((head.pre_len != '0) && (idx_reg < num_w))
        begin
            if (k_full < RUN_W'(head.sig))
            begin
                byte_sel = CH_ZERO | {4'h0, head.digits[k]};
            end
            else
            begin
                byte_sel = CH_SPACE;
            end
        end
        else if (idx_reg == num_w && head.pre_len != '0)
        begin
            byte_sel = CH_TAB;
        end
        else
        begin
            byte_sel = head.body[body_pos[1:0]];
        end
    end

    // Position and output valid update
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = fire;
        end
        if (fire)
        begin
            idx_next = is_last ? '0 : idx_reg + RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= byte_sel;
            last_reg     <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    // Checks
    `TSLF_ASSERT(a_idx_in_run, !q_st.empty |-> (idx_reg < head.run_len), "run overrun")
    `TSLF_ASSERT(a_run_shape, !q_st.empty |-> (head.pre_len < head.run_len), "no character byte")
    `TSLF_ASSERT(a_hold_on_stall, (out_valid_reg && out_stall) |=> $stable(idx_reg), "stall lost")
    `TSLF_ASSERT_ALWAYS(a_idle_pos, (q_st.empty && !fire) |-> (idx_reg == '0), "idle mid-run")

endmodule

// ===== rtl/core/text_stream_line_formatter.sv =====
// Top level of the text stream line formatter: config registers, front, queue, back.
// Depends on tslf_pkg, tslf_front, tslf_queue and tslf_back.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------
//   in      | in_valid / in_stall  | in_byte
//   out     | out_valid / out_stall| out_byte, last_of_run
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One output byte per cycle while out_stall is low and a request is queued; an input
// byte gives 1 to 13 output bytes (up to eight digits and a tab, then up to four
// character bytes), sent via the single byte-wide output register in the back part.
// A dropped empty line is accepted without any output byte. Input stalls only when the
// two-entry request queue is full; the queue and the output register let either side
// stall on its own. Reset: counter 1, config 0.
module text_stream_line_formatter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);
    import tslf_pkg::*;

    tslf_cfg_t   cfg_reg, cfg_next;
    logic        push, pop;
    tslf_entry_t push_entry, head;
    tslf_qstat_t q_st;

    assign cfg_ready = 1'b1;

    // Configuration register writes; unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (tslf_reg_idx_t'(cfg_index))
                REG_NUM_NONBLANK:  cfg_next.nonblank_num  = cfg_data;
                REG_NUM_ALL:       cfg_next.every_num     = cfg_data;
                REG_SHOW_NONPRINT: cfg_next.show_nonprint = cfg_data;
                REG_TAB_MARK:      cfg_next.tab_mark      = cfg_data;
                REG_END_MARK:      cfg_next.end_mark      = cfg_data;
                REG_SQUEEZE:       cfg_next.blank_squeeze = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tslf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .cfg        (cfg_reg),
        .q_st       (q_st),
        .push       (push),
        .push_entry (push_entry)
    );

    tslf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_st       (q_st)
    );

    tslf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_st        (q_st),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// ===== dv/tslf_format_checker.sv =====
`timescale 1ns / 100ps
// Checker for the text stream line formatter: watches the input, output and register
// channels, predicts every formatted byte and compares results in order.
// Depends on tslf_pkg only.
module tslf_format_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     out_byte,
    input  logic                           last_of_run,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tslf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    output int                             mismatch_count,
    output int                             bytes_owed
);
    import tslf_pkg::*;

    localparam int MAX_REPORTS = 10;

    // One predicted output byte and its end-of-run flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_req_t;

    out_req_t   expected_bytes[$];
    logic [7:0] run_bytes[$];
    out_req_t   want;

    // Predictor copy of the block's registers and state
    tslf_cfg_t  settings;
    tslf_bcd_t  line_number;
    logic       at_line_start;
    logic [1:0] blank_lines;

    initial mismatch_count = 0;
    initial bytes_owed = 0;

    task automatic put_byte(input logic [7:0] b);
        run_bytes.push_back(b);
    endtask

    // Number right-justified in at least NUM_MIN_COLS columns, then a tab
    task automatic put_line_number();
        logic       started;
        logic [3:0] d;
        started = 1'b0;
        for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
            d = (line_number[k] > 4'd9) ? 4'd9 : line_number[k];
            if (d != 4'd0 || k == 0)
                started = 1'b1;
            if (started)
                put_byte(CH_ZERO + {4'd0, d});
            else if (k < NUM_MIN_COLS)
                put_byte(CH_SPACE);
        end
        put_byte(CH_TAB);
    endtask

    // BCD increment, holding at all nines
    task automatic bump_line_number();
        logic full;
        full = 1'b1;
        for (int k = 0; k < NUMBER_DIGITS; k++)
            if (line_number[k] != 4'd9)
                full = 1'b0;
        if (full)
            return;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (line_number[k] >= 4'd9) begin
                line_number[k] = 4'd0;
            end
            else begin
                line_number[k] = line_number[k] + 4'd1;
                return;
            end
        end
    endtask

    // Caret and M- rendering of control and high bytes
    task automatic put_visible(input logic [7:0] c);
        if (c == CH_DEL) begin
            put_byte(CH_CARET);
            put_byte(CH_QMARK);
        end
        else if (c <= CH_CTRL_MAX) begin
            put_byte(CH_CARET);
            put_byte(c + CH_CTRL_OFS);
        end
        else if (c >= CH_HI_CTRL_MIN && c <= CH_HI_CTRL_MAX) begin
            put_byte(CH_M);
            put_byte(CH_DASH);
            put_byte(CH_CARET);
            put_byte(c - CH_HI_CTRL_MIN + CH_CTRL_OFS);
        end
        else if (c == CH_HI_DEL) begin
            put_byte(CH_M);
            put_byte(CH_DASH);
            put_byte(CH_CARET);
            put_byte(CH_QMARK);
        end
        else if (c > CH_HI_CTRL_MAX) begin
            put_byte(CH_M);
            put_byte(CH_DASH);
            put_byte(c - CH_HI_CTRL_MIN);
        end
        else begin
            put_byte(c);
        end
    endtask

    // Expected output run for one accepted input byte
    task automatic format_byte(input logic [7:0] c);
        run_bytes.delete();

        // second and later empty lines vanish in squeeze mode
        if (settings.blank_squeeze && at_line_start && c == CH_NL) begin
            if (blank_lines < 2'd2)
                blank_lines = blank_lines + 2'd1;
            if (blank_lines > 2'd1)
                return;
        end

        // nonblank numbering takes precedence over numbering every line
        if (at_line_start) begin
            if (settings.nonblank_num) begin
                if (c != CH_NL) begin
                    put_line_number();
                    bump_line_number();
                end
            end
            else if (settings.every_num) begin
                put_line_number();
                bump_line_number();
            end
        end

        if (settings.tab_mark && c == CH_TAB) begin
            put_byte(CH_CARET);
            put_byte(CH_I);
        end
        else if (settings.show_nonprint && c != CH_NL && c != CH_TAB) begin
            put_visible(c);
        end
        else begin
            if (settings.end_mark && c == CH_NL)
                put_byte(CH_DOLLAR);
            put_byte(c);
        end

        if (c == CH_NL) begin
            at_line_start = 1'b1;
        end
        else begin
            blank_lines = 2'd0;
            at_line_start = 1'b0;
        end

        foreach (run_bytes[i])
            expected_bytes.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
    endtask

    // Compare outputs first: a result at this edge stems from earlier requests
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settings = '0;
            line_number = '0;
            line_number[0] = 4'd1;
            at_line_start = 1'b1;
            blank_lines = 2'd0;
            expected_bytes.delete();
            bytes_owed = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected output byte %02h last %0b",
                                 $realtime, out_byte, last_of_run);
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data || last_of_run !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                                     $realtime, want.data, want.last, out_byte, last_of_run);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_NONBLANK:  settings.nonblank_num = cfg_data;
                    REG_NUM_ALL:       settings.every_num = cfg_data;
                    REG_SHOW_NONPRINT: settings.show_nonprint = cfg_data;
                    REG_TAB_MARK:      settings.tab_mark = cfg_data;
                    REG_END_MARK:      settings.end_mark = cfg_data;
                    REG_SQUEEZE:       settings.blank_squeeze = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                format_byte(in_byte);

            bytes_owed = expected_bytes.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the text stream line formatter: clock, reset, stimulus and verdict.
// Depends on tslf_pkg, text_stream_line_formatter and tslf_format_checker.
module tb;
    import tslf_pkg::*;

    localparam int PHASE_ITEMS   = 30;
    localparam int PHASE_COUNT   = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_LIMIT    = 2000;

    // Indexes past the last register: writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           in_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 last_of_run;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_NONBLANK;
    logic                 cfg_data = 1'b0;

    int   mismatch_count;
    int   bytes_owed;

    // Traffic shaping: steady is shared by sender and receiver, the hold flags are for the receiver
    bit   steady = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;

    logic [7:0] probe_bytes[$];

    text_stream_line_formatter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tslf_format_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .bytes_owed     (bytes_owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // One register write; valid is left high for a following write
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all six registers, plus one write to a spare index
    task automatic write_settings(input tslf_cfg_t mode);
        cfg_put(REG_NUM_NONBLANK,  mode.nonblank_num);
        cfg_put(REG_NUM_ALL,       mode.every_num);
        cfg_put(REG_SHOW_NONPRINT, mode.show_nonprint);
        cfg_put(REG_TAB_MARK,      mode.tab_mark);
        cfg_put(REG_END_MARK,      mode.end_mark);
        cfg_put(REG_SQUEEZE,       mode.blank_squeeze);
        cfg_put($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 1'($urandom_range(1)));
        cfg_valid <= 1'b0;
    endtask

    // Offer one byte, with an occasional gap first; valid stays high afterwards
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!steady && $urandom_range(99) < 17) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    // Lower valid, wait for every predicted byte, then let dropped lines settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random text: printable characters, newlines, blank runs, tabs and raw bytes
    task automatic send_text(input int count);
        int pick;
        int sent;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat (3) send_byte(CH_NL);
                sent += 3;
            end
            else begin
                if (pick < 26)
                    send_byte(CH_NL);
                else if (pick < 34)
                    send_byte(CH_TAB);
                else if (pick < 52)
                    send_byte(8'($urandom_range(255)));
                else
                    send_byte(8'($urandom_range(126, 32)));
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                out_stall <= !steady && ($urandom_range(99) < 25);
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        tslf_cfg_t mode;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both numbering modes, nonprinting shown, tabs raw, ends and squeeze on.
        // Field order: nonblank, all, nonprint, tabs, ends, squeeze.
        write_settings(6'b111011);
        probe_bytes = '{8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'h9F,
                        8'hA0, 8'hFE, 8'hFF, 8'h20, 8'h7E, 8'h09, 8'h0A, 8'h0A, 8'h0A,
                        8'h41, 8'h0A};
        foreach (probe_bytes[i])
            send_byte(probe_bytes[i]);
        drain();

        // Every line numbered, tabs shown
        write_settings(6'b010100);
        probe_bytes = '{8'h09, 8'h0A, 8'h0A, 8'h09, 8'h0A};
        foreach (probe_bytes[i])
            send_byte(probe_bytes[i]);
        drain();

        // Random phases: all on, all off, two fixed mixes, then random settings
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: mode = 6'b111111;
                1: mode = 6'b000000;
                2: mode = 6'b010010;
                3: mode = 6'b100101;
                default: mode = 6'($urandom_range(63));
            endcase
            write_settings(mode);
            hold_go = (p == 1);
            steady  = (p == 2);
            send_text(PHASE_ITEMS);
            drain();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
